### rtl/ihc_pkg.sv
// Shared constants, verdict codes and snapshot type for the IPv4 header checker.
package ihc_pkg;

  // Verdict codes
  localparam logic [2:0] VERDICT_DELIVER   = 3'd0;
  localparam logic [2:0] VERDICT_SHORT     = 3'd1;
  localparam logic [2:0] VERDICT_VERSION   = 3'd2;
  localparam logic [2:0] VERDICT_TRUNCATED = 3'd3;
  localparam logic [2:0] VERDICT_LENGTH    = 3'd4;
  localparam logic [2:0] VERDICT_CHECKSUM  = 3'd5;
  localparam logic [2:0] VERDICT_FRAGMENT  = 3'd6;
  localparam logic [2:0] VERDICT_PROTOCOL  = 3'd7;

  // Header byte positions
  localparam logic [15:0] POS_VER_IHL  = 16'd0;
  localparam logic [15:0] POS_TLEN_HI  = 16'd2;
  localparam logic [15:0] POS_TLEN_LO  = 16'd3;
  localparam logic [15:0] POS_FRAG_HI  = 16'd6;
  localparam logic [15:0] POS_FRAG_LO  = 16'd7;
  localparam logic [15:0] POS_PROTO    = 16'd9;
  localparam logic [15:0] POS_SRC_0    = 16'd12;
  localparam logic [15:0] POS_SRC_1    = 16'd13;
  localparam logic [15:0] POS_SRC_2    = 16'd14;
  localparam logic [15:0] POS_SRC_3    = 16'd15;

  // Header checks
  localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
  localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
  localparam logic [3:0]  VERSION_IPV4     = 4'd4;
  localparam logic [3:0]  MIN_IHL          = 4'd5;
  localparam logic [15:0] SUM_GOOD         = 16'hFFFF;
  localparam logic [15:0] FRAG_MF_MASK     = 16'h2000;
  localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1FFF;
  localparam logic [7:0]  DELIVER_PROTOCOL_RESET = 8'd6;

  // Header fields as they stand after the last byte of a packet
  typedef struct packed {
    logic [15:0] byte_count;
    logic [7:0]  version_ihl;
    logic [15:0] tot_len;
    logic [15:0] flags_fragment;
    logic [7:0]  protocol;
    logic [31:0] source;
    logic [15:0] checksum_sum;
  } hdr_snap_t;

endpackage

### rtl/ihc_in_if.sv
// Byte stream channel into the IPv4 header checker.
interface ihc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

### rtl/ihc_out_if.sv
// Verdict channel out of the IPv4 header checker.
interface ihc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [7:0]  protocol_number;
  logic [31:0] source_address;
  logic [5:0]  payload_offset;
  logic [15:0] payload_length;

  modport source (output valid, output verdict, output protocol_number,
                  output source_address, output payload_offset,
                  output payload_length, input ready);
  modport sink (input valid, input verdict, input protocol_number,
                input source_address, input payload_offset,
                input payload_length, output ready);
endinterface

### rtl/ipv4_header_checker_unit.sv
// Top level of the IPv4 header checker: protocol register, parser and verdict stage.
//
//   channel  dir  handshake      content
//   pkt      in   valid/ready    data_byte, last (one packet byte per request)
//   res      out  valid/ready    verdict, protocol_number, source_address,
//                                payload_offset, payload_length
//   cfg      in   cfg_wr_en      cfg_wr_data -> deliver_protocol
//
// Takes one byte per cycle while pkt.ready is high; the parser adds one header word
// every two bytes. A verdict passes the snapshot register, then the result register,
// after the last byte of a packet is accepted.
// Synchronous reset clears per-packet state and sets deliver_protocol to 6.
// A stalled result holds the snapshot; a held snapshot drops pkt.ready.
module ipv4_header_checker_unit (
  input  logic       clk,
  input  logic       rst,
  ihc_in_if.sink     pkt,
  ihc_out_if.source  res,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0]         deliver_protocol;
  logic               snap_valid;
  logic               snap_ready;
  ihc_pkg::hdr_snap_t snap;

  // Hold the configured protocol number
  always_ff @(posedge clk) begin
    if (rst) begin
      deliver_protocol <= ihc_pkg::DELIVER_PROTOCOL_RESET;
    end else if (cfg_wr_en) begin
      deliver_protocol <= cfg_wr_data;
    end
  end

  ihc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (pkt.valid),
    .data_byte  (pkt.data_byte),
    .last       (pkt.last),
    .snap_ready (snap_ready),
    .byte_ready (pkt.ready),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  ihc_verdict u_verdict (
    .clk              (clk),
    .rst              (rst),
    .snap_valid       (snap_valid),
    .snap             (snap),
    .deliver_protocol (deliver_protocol),
    .snap_ready       (snap_ready),
    .res              (res)
  );

endmodule

### rtl/ihc_parser.sv
// Per-byte header capture and checksum accumulation, with end-of-packet snapshot.
module ihc_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic [7:0]        data_byte,
  input  logic              last,
  input  logic              snap_ready,
  output logic              byte_ready,
  output logic              snap_valid,
  output ihc_pkg::hdr_snap_t snap
);

  logic [15:0] byte_count;
  logic [7:0]  version_ihl;
  logic [15:0] tot_len;
  logic [15:0] flags_fragment;
  logic [7:0]  protocol;
  logic [31:0] source;
  logic [15:0] checksum_sum;
  logic [7:0]  high_byte_hold;

  logic [15:0] byte_count_next;
  logic [7:0]  version_ihl_next;
  logic [15:0] tot_len_next;
  logic [15:0] flags_fragment_next;
  logic [7:0]  protocol_next;
  logic [31:0] source_next;
  logic [15:0] checksum_sum_next;
  logic [7:0]  high_byte_hold_next;

  logic [5:0]  hdr_len;
  logic [16:0] word_sum;
  logic [16:0] word_fold;
  logic        accept;

  // Stall input only when a finished snapshot cannot move on
  assign byte_ready = !snap_valid || snap_ready;
  assign accept     = byte_valid && byte_ready;

  // Capture header fields at their positions
  always_comb begin
    version_ihl_next    = version_ihl;
    tot_len_next        = tot_len;
    flags_fragment_next = flags_fragment;
    protocol_next       = protocol;
    source_next         = source;
    case (byte_count)
      ihc_pkg::POS_VER_IHL: version_ihl_next            = data_byte;
      ihc_pkg::POS_TLEN_HI: tot_len_next[15:8]          = data_byte;
      ihc_pkg::POS_TLEN_LO: tot_len_next[7:0]           = data_byte;
      ihc_pkg::POS_FRAG_HI: flags_fragment_next[15:8]   = data_byte;
      ihc_pkg::POS_FRAG_LO: flags_fragment_next[7:0]    = data_byte;
      ihc_pkg::POS_PROTO:   protocol_next               = data_byte;
      ihc_pkg::POS_SRC_0:   source_next[31:24]          = data_byte;
      ihc_pkg::POS_SRC_1:   source_next[23:16]          = data_byte;
      ihc_pkg::POS_SRC_2:   source_next[15:8]           = data_byte;
      ihc_pkg::POS_SRC_3:   source_next[7:0]            = data_byte;
      default: ;
    endcase
  end

  // Add header words into the folded ones-complement sum
  assign hdr_len   = {version_ihl_next[3:0], 2'b00};
  assign word_sum  = {1'b0, checksum_sum} + {1'b0, high_byte_hold, data_byte};
  assign word_fold = {1'b0, word_sum[15:0]} + {16'd0, word_sum[16]};

  always_comb begin
    checksum_sum_next   = checksum_sum;
    high_byte_hold_next = high_byte_hold;
    if (byte_count < {10'd0, hdr_len}) begin
      if (!byte_count[0]) begin
        high_byte_hold_next = data_byte;
      end else begin
        checksum_sum_next = word_fold[15:0];
      end
    end
  end

  // Saturate the byte count
  assign byte_count_next = (byte_count == ihc_pkg::COUNT_MAX) ? byte_count
                                                              : byte_count + 16'd1;

  // Advance per-packet state, clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      version_ihl    <= '0;
      tot_len        <= '0;
      flags_fragment <= '0;
      protocol       <= '0;
      source         <= '0;
      checksum_sum   <= '0;
      high_byte_hold <= '0;
    end else if (accept) begin
      if (last) begin
        byte_count     <= '0;
        version_ihl    <= '0;
        tot_len        <= '0;
        flags_fragment <= '0;
        protocol       <= '0;
        source         <= '0;
        checksum_sum   <= '0;
        high_byte_hold <= '0;
      end else begin
        byte_count     <= byte_count_next;
        version_ihl    <= version_ihl_next;
        tot_len        <= tot_len_next;
        flags_fragment <= flags_fragment_next;
        protocol       <= protocol_next;
        source         <= source_next;
        checksum_sum   <= checksum_sum_next;
        high_byte_hold <= high_byte_hold_next;
      end
    end
  end

  // Hold the finished header until the verdict stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (byte_ready) begin
      snap_valid <= accept && last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      snap.byte_count     <= byte_count_next;
      snap.version_ihl    <= version_ihl_next;
      snap.tot_len        <= tot_len_next;
      snap.flags_fragment <= flags_fragment_next;
      snap.protocol       <= protocol_next;
      snap.source         <= source_next;
      snap.checksum_sum   <= checksum_sum_next;
    end
  end

endmodule

### rtl/ihc_verdict.sv
// Ordered header checks on a packet snapshot, into the result register.
module ihc_verdict (
  input  logic               clk,
  input  logic               rst,
  input  logic               snap_valid,
  input  ihc_pkg::hdr_snap_t snap,
  input  logic [7:0]         deliver_protocol,
  output logic               snap_ready,
  ihc_out_if.source          res
);

  logic [3:0]  version;
  logic [3:0]  ihl;
  logic [5:0]  hdr_len;
  logic [15:0] hdr_len_w;
  logic [2:0]  verdict_next;
  logic        pass_len;

  assign version   = snap.version_ihl[7:4];
  assign ihl       = snap.version_ihl[3:0];
  assign hdr_len   = {ihl, 2'b00};
  assign hdr_len_w = {10'd0, hdr_len};

  // Take the first failing check in priority order
  always_comb begin
    if (snap.byte_count < ihc_pkg::MIN_HEADER_BYTES) begin
      verdict_next = ihc_pkg::VERDICT_SHORT;
    end else if (version != ihc_pkg::VERSION_IPV4 || ihl < ihc_pkg::MIN_IHL) begin
      verdict_next = ihc_pkg::VERDICT_VERSION;
    end else if (hdr_len_w > snap.byte_count) begin
      verdict_next = ihc_pkg::VERDICT_TRUNCATED;
    end else if (snap.tot_len < hdr_len_w ||
                 snap.tot_len > snap.byte_count) begin
      verdict_next = ihc_pkg::VERDICT_LENGTH;
    end else if (snap.checksum_sum != ihc_pkg::SUM_GOOD) begin
      verdict_next = ihc_pkg::VERDICT_CHECKSUM;
    end else if ((snap.flags_fragment & ihc_pkg::FRAG_MF_MASK) != 16'd0 ||
                 (snap.flags_fragment & ihc_pkg::FRAG_OFFSET_MASK) != 16'd0) begin
      verdict_next = ihc_pkg::VERDICT_FRAGMENT;
    end else if (snap.protocol != deliver_protocol) begin
      verdict_next = ihc_pkg::VERDICT_PROTOCOL;
    end else begin
      verdict_next = ihc_pkg::VERDICT_DELIVER;
    end
  end

  // Report offset and length only for delivered or other-protocol packets
  assign pass_len = (verdict_next == ihc_pkg::VERDICT_DELIVER) ||
                    (verdict_next == ihc_pkg::VERDICT_PROTOCOL);

  assign snap_ready = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (snap_ready) begin
      res.valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      res.verdict         <= verdict_next;
      res.protocol_number <= snap.protocol;
      res.source_address  <= snap.source;
      res.payload_offset  <= pass_len ? hdr_len : 6'd0;
      res.payload_length  <= pass_len ? snap.tot_len - hdr_len_w : 16'd0;
    end
  end

endmodule

### tb/sv/tb_top.sv
// Testbench for ipv4_header_checker_unit: directed and random packets against a verdict predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ihc_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 120;
  localparam int NO_VERDICT   = -1;
  localparam int SAME_AS_LEN  = -1;
  localparam int KEEP_CFG     = -1;

  // Checksum handling when a packet is built
  localparam int CKS_RANDOM = 0;
  localparam int CKS_VALID  = 1;
  localparam int CKS_BROKEN = 2;

  localparam logic [15:0] POS_CKS_HI = 16'd10;
  localparam logic [15:0] POS_CKS_LO = 16'd11;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [5:0]  pay_off;
    logic [15:0] pay_len;
  } verdict_rec_t;

  typedef struct {
    int          cfg;
    int          len;
    logic [7:0]  vi;
    int          tlen;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [31:0] src;
    int          cks;
    int          want;
  } pkt_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  ihc_in_if  pkt_if ();
  ihc_out_if res_if ();

  ipv4_header_checker_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .pkt         (pkt_if),
    .res         (res_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predictor state, a private copy of the per-packet header capture
  logic [15:0] seen_count;
  logic [7:0]  vi_byte;
  logic [15:0] tlen_word;
  logic [15:0] frag_word;
  logic [7:0]  proto_byte;
  logic [31:0] src_word;
  logic [16:0] hdr_sum;
  logic [7:0]  hi_byte;
  logic [7:0]  deliver_setting;

  verdict_rec_t pending_verdicts[$];
  int           stated_verdicts[$];
  int           mismatch_count;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           holds_asked;
  int           holds_done;
  int           hold_left;
  pkt_row_t     directed_rows[19];

  always #6 clk = ~clk;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
             cycle_count, what, got, want);
  endtask

  task automatic clear_capture();
    seen_count = '0;
    vi_byte    = '0;
    tlen_word  = '0;
    frag_word  = '0;
    proto_byte = '0;
    src_word   = '0;
    hdr_sum    = '0;
    hi_byte    = '0;
  endtask

  // Advance the header capture by one byte; on the last byte queue the verdict
  task automatic predict_byte(input logic [7:0] b, input logic is_last);
    logic [15:0]  pos;
    logic [5:0]   hlen;
    logic [15:0]  hlen_w;
    logic [17:0]  s;
    verdict_rec_t r;
    int           stated;
    pos = seen_count;
    case (pos)
      POS_VER_IHL: vi_byte = b;
      POS_TLEN_HI: tlen_word[15:8] = b;
      POS_TLEN_LO: tlen_word[7:0] = b;
      POS_FRAG_HI: frag_word[15:8] = b;
      POS_FRAG_LO: frag_word[7:0] = b;
      POS_PROTO:   proto_byte = b;
      POS_SRC_0:   src_word[31:24] = b;
      POS_SRC_1:   src_word[23:16] = b;
      POS_SRC_2:   src_word[15:8] = b;
      POS_SRC_3:   src_word[7:0] = b;
      default: ;
    endcase
    hlen = {vi_byte[3:0], 2'b00};
    hlen_w = {10'd0, hlen};

    // Sum header words only, folding the carry after each word
    if (pos < hlen_w) begin
      if (!pos[0]) begin
        hi_byte = b;
      end else begin
        s = {1'b0, hdr_sum} + {2'b00, hi_byte, b};
        hdr_sum = {1'b0, s[15:0]} + {15'd0, s[17:16]};
      end
    end
    if (seen_count != COUNT_MAX) seen_count = seen_count + 16'd1;
    if (!is_last) return;

    r = '0;
    r.proto = proto_byte;
    r.src_addr = src_word;
    if (seen_count < MIN_HEADER_BYTES)
      r.verdict = VERDICT_SHORT;
    else if (vi_byte[7:4] != VERSION_IPV4 || vi_byte[3:0] < MIN_IHL)
      r.verdict = VERDICT_VERSION;
    else if (hlen_w > seen_count)
      r.verdict = VERDICT_TRUNCATED;
    else if (tlen_word < hlen_w || tlen_word > seen_count)
      r.verdict = VERDICT_LENGTH;
    else if (hdr_sum[15:0] != SUM_GOOD)
      r.verdict = VERDICT_CHECKSUM;
    else if ((frag_word & FRAG_MF_MASK) != 16'd0 || (frag_word & FRAG_OFFSET_MASK) != 16'd0)
      r.verdict = VERDICT_FRAGMENT;
    else if (proto_byte != deliver_setting)
      r.verdict = VERDICT_PROTOCOL;
    else
      r.verdict = VERDICT_DELIVER;

    // Offset and length survive only on deliver and on other protocol
    if (r.verdict == VERDICT_DELIVER || r.verdict == VERDICT_PROTOCOL) begin
      r.pay_off = hlen;
      r.pay_len = tlen_word - hlen_w;
    end

    // Cross-check against the verdict typed into the directed table
    stated = (stated_verdicts.size() != 0) ? stated_verdicts.pop_front() : NO_VERDICT;
    if (stated != NO_VERDICT && stated != int'(r.verdict))
      flag_mismatch("predicted verdict vs table", 32'(r.verdict), 32'(stated));
    pending_verdicts.push_back(r);
    clear_capture();
  endtask

  // Watch both channels; predict on each accepted request, check each verdict
  always @(posedge clk) begin
    verdict_rec_t want;
    if (!rst) begin
      if (pkt_if.valid && pkt_if.ready)
        predict_byte(pkt_if.data_byte, pkt_if.last);
      if (res_if.valid && res_if.ready) begin
        if (pending_verdicts.size() == 0) begin
          flag_mismatch("verdict with none pending", 32'(res_if.verdict), 32'd0);
        end else begin
          want = pending_verdicts.pop_front();
          if (res_if.verdict !== want.verdict)
            flag_mismatch("verdict", 32'(res_if.verdict), 32'(want.verdict));
          if (res_if.protocol_number !== want.proto)
            flag_mismatch("protocol_number", 32'(res_if.protocol_number), 32'(want.proto));
          if (res_if.source_address !== want.src_addr)
            flag_mismatch("source_address", res_if.source_address, want.src_addr);
          if (res_if.payload_offset !== want.pay_off)
            flag_mismatch("payload_offset", 32'(res_if.payload_offset), 32'(want.pay_off));
          if (res_if.payload_length !== want.pay_len)
            flag_mismatch("payload_length", 32'(res_if.payload_length), 32'(want.pay_len));
        end
      end
    end
  end

  // Drive result ready: random gaps, or a long hold when one is asked for
  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      res_if.ready <= 1'b0;
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Give up when the run takes far longer than it should
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("ipv4_header_checker_unit test failed");
      $finish;
    end
  end

  // Offer one byte, idling at random first, and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_if.valid <= 1'b0;
      @(posedge clk);
    end
    pkt_if.valid     <= 1'b1;
    pkt_if.data_byte <= b;
    pkt_if.last      <= is_last;
    @(posedge clk);
    while (!pkt_if.ready) @(posedge clk);
  endtask

  // Build a packet over random bytes, place header fields, then send it
  task automatic send_packet(input int len, input logic [7:0] vi, input logic [15:0] tlen,
                             input logic [15:0] frag, input logic [7:0] proto,
                             input logic [31:0] src, input int cks_mode, input int stated);
    logic [7:0]  pkt[];
    int          hlen;
    logic [31:0] acc;
    logic [15:0] cks;
    pkt = new[len];
    foreach (pkt[i]) pkt[i] = 8'($urandom_range(255));
    for (int k = 0; k < len && k < 16; k++) begin
      case (16'(k))
        POS_VER_IHL: pkt[k] = vi;
        POS_TLEN_HI: pkt[k] = tlen[15:8];
        POS_TLEN_LO: pkt[k] = tlen[7:0];
        POS_FRAG_HI: pkt[k] = frag[15:8];
        POS_FRAG_LO: pkt[k] = frag[7:0];
        POS_PROTO:   pkt[k] = proto;
        POS_SRC_0:   pkt[k] = src[31:24];
        POS_SRC_1:   pkt[k] = src[23:16];
        POS_SRC_2:   pkt[k] = src[15:8];
        POS_SRC_3:   pkt[k] = src[7:0];
        default: ;
      endcase
    end

    // Fill in the header checksum, unless it is left random, when the whole header is present
    hlen = int'(vi[3:0]) * 4;
    if (cks_mode != CKS_RANDOM && len >= hlen && hlen >= 12) begin
      pkt[POS_CKS_HI] = 8'h00;
      pkt[POS_CKS_LO] = 8'h00;
      acc = 0;
      for (int k = 0; k < hlen; k += 2) begin
        acc = acc + {16'd0, pkt[k], pkt[k + 1]};
        acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
      end
      cks = ~acc[15:0];
      if (cks_mode == CKS_BROKEN) cks = cks ^ 16'h0001;
      pkt[POS_CKS_HI] = cks[15:8];
      pkt[POS_CKS_LO] = cks[7:0];
    end

    stated_verdicts.push_back(stated);
    for (int k = 0; k < len; k++) send_byte(pkt[k], k == len - 1);
  endtask

  // Hold the sender until every verdict is in, then let the pipe empty
  task automatic settle();
    pkt_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_protocol(input logic [7:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    deliver_setting = v;
  endtask

  // Mostly well-formed packets, some with one fault, some pure noise
  task automatic random_packet(output int len);
    int          kind;
    int          ihl;
    int          tlen;
    int          cks;
    logic [7:0]  vi;
    logic [7:0]  proto;
    logic [15:0] frag;
    kind  = $urandom_range(99);
    ihl   = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
    len   = ihl * 4 + $urandom_range(12);
    tlen  = ($urandom_range(4) == 0) ? len - $urandom_range(len - ihl * 4) : len;
    frag  = {2'($urandom_range(3)), 14'd0};
    proto = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : deliver_setting;
    vi    = {VERSION_IPV4, 4'(ihl)};
    cks   = CKS_VALID;
    if (kind >= 85) begin
      len   = $urandom_range(40, 1);
      vi    = 8'($urandom_range(255));
      tlen  = $urandom_range(65535);
      frag  = 16'($urandom_range(65535));
      proto = 8'($urandom_range(255));
      cks   = CKS_RANDOM;
    end else if (kind >= 65) begin
      case ($urandom_range(5))
        0: vi[7:4] = 4'($urandom_range(15));
        1: vi[3:0] = 4'($urandom_range(4));
        2: len = $urandom_range(ihl * 4 - 1, 1);
        3: tlen = ($urandom_range(1) == 0) ? $urandom_range(ihl * 4 - 1)
                                           : len + $urandom_range(100, 1);
        4: cks = CKS_BROKEN;
        default: frag = frag | (($urandom_range(1) == 0) ? FRAG_MF_MASK
                                                         : 16'($urandom_range(8191, 1)));
      endcase
    end
    send_packet(len, vi, 16'(tlen), frag, proto, $urandom(), cks, NO_VERDICT);
  endtask

  task automatic random_burst(input int byte_goal, input int pkt_goal);
    int sent;
    int pkts;
    int len;
    sent = 0;
    pkts = 0;
    while (sent < byte_goal || pkts < pkt_goal) begin
      random_packet(len);
      sent += len;
      pkts++;
    end
  endtask

  initial begin
    pkt_row_t row;
    int       tlen;
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    pkt_if.valid = 1'b0;
    pkt_if.data_byte = '0;
    pkt_if.last = 1'b0;
    res_if.ready = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    holds_asked = 0;
    holds_done = 0;
    hold_left = 0;
    send_idle_pct = 6;
    recv_idle_pct = 56;
    deliver_setting = DELIVER_PROTOCOL_RESET;
    clear_capture();

    // cfg, len, ver/ihl, total length, flags/frag, protocol, source, checksum, verdict
    directed_rows = '{
      '{KEEP_CFG, 1, 8'h45, SAME_AS_LEN, 16'h0000, 8'd6, 32'h0A000001, CKS_VALID,
        VERDICT_SHORT},
      '{KEEP_CFG, 19, 8'h45, 19, 16'h0000, 8'd6, 32'h0A000002, CKS_VALID, VERDICT_SHORT},
      '{KEEP_CFG, 20, 8'h45, SAME_AS_LEN, 16'h0000, 8'd6, 32'hC0A80001, CKS_VALID,
        VERDICT_DELIVER},
      '{KEEP_CFG, 20, 8'h65, SAME_AS_LEN, 16'h0000, 8'd6, 32'h01020304, CKS_VALID,
        VERDICT_VERSION},
      '{KEEP_CFG, 20, 8'h44, SAME_AS_LEN, 16'h0000, 8'd6, 32'h05060708, CKS_VALID,
        VERDICT_VERSION},
      '{KEEP_CFG, 24, 8'h40, SAME_AS_LEN, 16'h0000, 8'd6, 32'h090A0B0C, CKS_VALID,
        VERDICT_VERSION},
      '{KEEP_CFG, 20, 8'hFF, SAME_AS_LEN, 16'h0000, 8'd6, 32'h0D0E0F10, CKS_VALID,
        VERDICT_VERSION},
      '{KEEP_CFG, 40, 8'h4F, SAME_AS_LEN, 16'h0000, 8'd6, 32'h11121314, CKS_VALID,
        VERDICT_TRUNCATED},
      '{KEEP_CFG, 30, 8'h45, 19, 16'h0000, 8'd6, 32'h15161718, CKS_VALID, VERDICT_LENGTH},
      '{KEEP_CFG, 30, 8'h45, 31, 16'h0000, 8'd6, 32'h191A1B1C, CKS_VALID, VERDICT_LENGTH},
      '{KEEP_CFG, 20, 8'h45, 0, 16'h0000, 8'd6, 32'h1D1E1F20, CKS_VALID, VERDICT_LENGTH},
      '{KEEP_CFG, 30, 8'h45, SAME_AS_LEN, 16'h0000, 8'd6, 32'h21222324, CKS_BROKEN,
        VERDICT_CHECKSUM},
      '{KEEP_CFG, 20, 8'h45, SAME_AS_LEN, 16'h2000, 8'd6, 32'h25262728, CKS_VALID,
        VERDICT_FRAGMENT},
      '{KEEP_CFG, 20, 8'h45, SAME_AS_LEN, 16'h0001, 8'd6, 32'h292A2B2C, CKS_VALID,
        VERDICT_FRAGMENT},
      '{KEEP_CFG, 28, 8'h45, 24, 16'h0000, 8'd17, 32'h2D2E2F30, CKS_VALID,
        VERDICT_PROTOCOL},
      '{KEEP_CFG, 64, 8'h4F, SAME_AS_LEN, 16'h0000, 8'd6, 32'hFFFFFFFF, CKS_VALID,
        VERDICT_DELIVER},
      '{0, 20, 8'h45, SAME_AS_LEN, 16'h4000, 8'd0, 32'h00000000, CKS_VALID,
        VERDICT_DELIVER},
      '{255, 33, 8'h46, 32, 16'h8000, 8'd255, 32'h80000001, CKS_VALID, NO_VERDICT},
      '{KEEP_CFG, 20, 8'h45, SAME_AS_LEN, 16'h0000, 8'd254, 32'h7FFFFFFE, CKS_VALID,
        VERDICT_PROTOCOL}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed packets, sender idling lightly and receiver heavily
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.cfg != KEEP_CFG) set_protocol(8'(row.cfg));
      tlen = (row.tlen != SAME_AS_LEN) ? row.tlen : ((row.len > 65535) ? 65535 : row.len);
      send_packet(row.len, row.vi, 16'(tlen), row.frag, row.proto, row.src, row.cks,
                  row.want);
    end
    random_burst(200, 8);

    // Swap the idling: sender idles heavily, receiver lightly
    set_protocol(8'($urandom_range(255)));
    send_idle_pct = 56;
    recv_idle_pct = 6;
    random_burst(200, 8);

    // No idling; fill the block behind a long receiver hold
    set_protocol(DELIVER_PROTOCOL_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_asked = holds_asked + 1;
    repeat (4)
      send_packet(20, 8'h45, 16'd20, 16'h0000, deliver_setting, $urandom(), CKS_VALID,
                  VERDICT_DELIVER);
    settle();
    random_burst(200, 8);

    settle();
    repeat (8) @(posedge clk);
    if (pending_verdicts.size() != 0)
      flag_mismatch("verdicts never delivered", pending_verdicts.size(), 32'd0);
    if (mismatch_count == 0) begin
      $display("ipv4_header_checker_unit test passed");
    end else begin
      $display("ipv4_header_checker_unit test failed");
    end
    $finish;
  end

endmodule

### ipv4_header_checker_unit.f
rtl/ihc_pkg.sv
rtl/ihc_in_if.sv
rtl/ihc_out_if.sv
rtl/ihc_parser.sv
rtl/ihc_verdict.sv
rtl/ipv4_header_checker_unit.sv
tb/sv/tb_top.sv
